/* design/ptrq_pkg.sv */
// Package for the priority tile request queue.
// Holds the operation codes, the controller states and the cell control types.
// Has no dependencies; every other design file imports it.
package ptrq_pkg;

  // Widths of the fixed port fields.
  localparam int KIND_W   = 4;
  localparam int HANDLE_W = 16;
  localparam int IMAGE_W  = 8;
  localparam int AREA_IN_W = 24;
  localparam int STATUS_W = 8;
  localparam int POS_W    = 5;
  localparam int FOUND_W  = 6;
  localparam int OCC_W    = 6;

  // Operation codes carried by in_kind.
  typedef enum logic [KIND_W-1:0] {
    K_ENQ    = 4'd0,
    K_TAKE   = 4'd1,
    K_RMLAST = 4'd2,
    K_FIND   = 4'd3,
    K_READ   = 4'd4,
    K_RMALL  = 4'd5,
    K_RMAT   = 4'd6,
    K_REPL   = 4'd7,
    K_CLEAR  = 4'd8
  } kind_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Action broadcast along the chain of cells.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DROP,
    CELL_WRITE
  } cell_op_t;

  // Per-cell compare results returned to the controller.
  typedef struct packed {
    logic match;  // live entry whose image equals the key
    logic keep;   // live entry that stays ahead of a prioritised item
  } cell_flag_t;

endpackage

/* design/ptrq_cell.sv */
// One queue slot of the priority tile request queue.
// Holds an entry, shifts it to or from its neighbours and compares it with the key.
// Depends on ptrq_pkg.
module ptrq_cell #(
  parameter int IDX = 0,
  parameter int IW  = 5,
  parameter int AW  = 24
) (
  input  logic                          clk,
  input  ptrq_pkg::cell_op_t            op,
  input  logic [IW-1:0]                 pos,
  input  logic                          live,
  input  logic [ptrq_pkg::HANDLE_W-1:0] new_handle,
  input  logic [ptrq_pkg::IMAGE_W-1:0]  new_image,
  input  logic [AW-1:0]                 new_area,
  input  logic                          new_high,
  input  logic [ptrq_pkg::STATUS_W-1:0] new_status,
  input  logic [ptrq_pkg::HANDLE_W-1:0] left_handle,
  input  logic [ptrq_pkg::IMAGE_W-1:0]  left_image,
  input  logic [AW-1:0]                 left_area,
  input  logic                          left_high,
  input  logic [ptrq_pkg::STATUS_W-1:0] left_status,
  input  logic [ptrq_pkg::HANDLE_W-1:0] right_handle,
  input  logic [ptrq_pkg::IMAGE_W-1:0]  right_image,
  input  logic [AW-1:0]                 right_area,
  input  logic                          right_high,
  input  logic [ptrq_pkg::STATUS_W-1:0] right_status,
  output logic [ptrq_pkg::HANDLE_W-1:0] handle_r,
  output logic [ptrq_pkg::IMAGE_W-1:0]  image_r,
  output logic [AW-1:0]                 area_r,
  output logic                          high_r,
  output logic [ptrq_pkg::STATUS_W-1:0] status_r,
  output ptrq_pkg::cell_flag_t          flag
);
  import ptrq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic take_new;
  logic take_left;
  logic take_right;

  // Decode the broadcast action against this slot's own index.
  always_comb begin
    take_new   = 1'b0;
    take_left  = 1'b0;
    take_right = 1'b0;
    case (op)
      CELL_INSERT: begin
        take_new  = (MY_IDX == pos);
        take_left = (MY_IDX > pos);
      end
      CELL_DROP: begin
        take_right = (MY_IDX >= pos);
      end
      CELL_WRITE: begin
        take_new = (MY_IDX == pos);
      end
      default: begin
      end
    endcase
  end

  // Entry storage: load the new item or a neighbour's entry.
  always_ff @(posedge clk) begin
    if (take_new) begin
      handle_r <= new_handle;
      image_r  <= new_image;
      area_r   <= new_area;
      high_r   <= new_high;
      status_r <= new_status;
    end else if (take_left) begin
      handle_r <= left_handle;
      image_r  <= left_image;
      area_r   <= left_area;
      high_r   <= left_high;
      status_r <= left_status;
    end else if (take_right) begin
      handle_r <= right_handle;
      image_r  <= right_image;
      area_r   <= right_area;
      high_r   <= right_high;
      status_r <= right_status;
    end
  end

  // Compare the stored entry with the search key and the new item's area.
  always_comb begin
    flag.match = live && (image_r == new_image);
    flag.keep  = live && high_r && (area_r > new_area);
  end

endmodule

/* design/priority_tile_request_queue.sv */
// Priority tile request queue: a chain of entry cells under a small controller.
// The result strobe is registered from the executing state that follows an accepted start;
// remove all by image stays in that state, dropping the last match until none is left.
// A new item is accepted only while idle; busy is high during execution.
// Reset clears the controller and the occupancy; entry contents are left as they are.
// The receiver cannot stall: each result is shown for one cycle with out_strobe.
module priority_tile_request_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int AREA_BITS   = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ptrq_pkg::KIND_W-1:0]          in_kind,
  input  logic [ptrq_pkg::HANDLE_W-1:0]        in_tile_handle,
  input  logic [ptrq_pkg::IMAGE_W-1:0]         in_image_key,
  input  logic [ptrq_pkg::AREA_IN_W-1:0]       in_tile_area,
  input  logic                                 in_high_mark,
  input  logic                                 in_prioritize,
  input  logic [ptrq_pkg::STATUS_W-1:0]        in_tile_status,
  input  logic [ptrq_pkg::POS_W-1:0]           in_position,
  output logic                                 out_strobe,
  output logic                                 out_ok,
  output logic [ptrq_pkg::HANDLE_W-1:0]        out_tile_out,
  output logic signed [ptrq_pkg::FOUND_W-1:0]  out_found_index,
  output logic [ptrq_pkg::OCC_W-1:0]           out_occupancy,
  output logic [ptrq_pkg::STATUS_W-1:0]        out_head_status
);
  import ptrq_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = 10;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Controller and command registers.
  state_t                state_r, state_nxt;
  kind_t                 kind_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [IMAGE_W-1:0]    image_r;
  logic [AREA_BITS-1:0]  area_r;
  logic                  high_r;
  logic                  prio_r;
  logic [STATUS_W-1:0]   status_r;
  logic [POS_W-1:0]      pos_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  any_r, any_nxt;
  logic                  strobe_r, strobe_nxt;
  logic                  ok_r, ok_nxt;
  logic [HANDLE_W-1:0]   tile_r, tile_nxt;
  logic [FOUND_W-1:0]    found_r, found_nxt;

  logic                  accept;
  logic                  done;
  cell_op_t              op;
  logic [IW-1:0]         op_pos;

  // Cell storage views.
  logic [HANDLE_W-1:0]   c_handle [QUEUE_DEPTH];
  logic [IMAGE_W-1:0]    c_image  [QUEUE_DEPTH];
  logic [AREA_BITS-1:0]  c_area   [QUEUE_DEPTH];
  logic                  c_high   [QUEUE_DEPTH];
  logic [STATUS_W-1:0]   c_status [QUEUE_DEPTH];
  cell_flag_t            c_flag   [QUEUE_DEPTH];

  logic [IW-1:0]         ins_at;
  logic                  lm_found;
  logic [IW-1:0]         lm_idx;
  logic                  pos_ok;
  logic [IW-1:0]         pos_idx;

  assign accept = start && (state_r == ST_IDLE);

  // The chain of cells, each linked to its two neighbours.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == QUEUE_DEPTH - 1) ? i : i + 1;
    ptrq_cell #(.IDX(i), .IW(IW), .AW(AREA_BITS)) u_cell (
      .clk          (clk),
      .op           (op),
      .pos          (op_pos),
      .live         (count_r > CW'(i)),
      .new_handle   (handle_r),
      .new_image    (image_r),
      .new_area     (area_r),
      .new_high     (high_r),
      .new_status   (status_r),
      .left_handle  (c_handle[L]),
      .left_image   (c_image[L]),
      .left_area    (c_area[L]),
      .left_high    (c_high[L]),
      .left_status  (c_status[L]),
      .right_handle (c_handle[R]),
      .right_image  (c_image[R]),
      .right_area   (c_area[R]),
      .right_high   (c_high[R]),
      .right_status (c_status[R]),
      .handle_r     (c_handle[i]),
      .image_r      (c_image[i]),
      .area_r       (c_area[i]),
      .high_r       (c_high[i]),
      .status_r     (c_status[i]),
      .flag         (c_flag[i])
    );
  end

  // Insertion point: the first live entry that does not stay ahead.
  always_comb begin
    ins_at = count_r[IW-1:0];
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if ((count_r > CW'(i)) && !c_flag[i].keep) begin
        ins_at = IW'(i);
      end
    end
  end

  // Last entry whose image matches the key.
  always_comb begin
    lm_found = 1'b0;
    lm_idx   = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (c_flag[i].match) begin
        lm_found = 1'b1;
        lm_idx   = IW'(i);
      end
    end
  end

  // Index range check done at a ten-bit width, which covers depths up to 1023.
  assign pos_ok  = WW'(pos_r) < WW'(count_r);
  assign pos_idx = IW'(pos_r);

  // Operation decode and result values for the executing item.
  always_comb begin
    op        = CELL_HOLD;
    op_pos    = '0;
    count_nxt = count_r;
    any_nxt   = any_r;
    ok_nxt    = ok_r;
    tile_nxt  = tile_r;
    found_nxt = found_r;
    done      = 1'b0;
    if (accept) begin
      any_nxt = 1'b0;
    end
    if (state_r == ST_EXEC) begin
      done      = 1'b1;
      ok_nxt    = 1'b0;
      tile_nxt  = '0;
      found_nxt = '1;
      case (kind_r)
        K_ENQ: begin
          if (count_r < DEPTH_C) begin
            op        = CELL_INSERT;
            op_pos    = prio_r ? ins_at : count_r[IW-1:0];
            count_nxt = count_r + 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        K_TAKE: begin
          if (count_r != '0) begin
            op        = CELL_DROP;
            op_pos    = '0;
            count_nxt = count_r - 1'b1;
            tile_nxt  = c_handle[0];
            ok_nxt    = 1'b1;
          end
        end
        K_RMLAST: begin
          if (lm_found) begin
            op        = CELL_DROP;
            op_pos    = lm_idx;
            count_nxt = count_r - 1'b1;
            found_nxt = FOUND_W'(lm_idx);
            ok_nxt    = 1'b1;
          end
        end
        K_FIND: begin
          if (lm_found) begin
            found_nxt = FOUND_W'(lm_idx);
            ok_nxt    = 1'b1;
          end
        end
        K_READ: begin
          if (pos_ok) begin
            tile_nxt = c_handle[pos_idx];
            ok_nxt   = 1'b1;
          end
        end
        K_RMALL: begin
          // Drop the last match each cycle until none is left.
          if (lm_found) begin
            op        = CELL_DROP;
            op_pos    = lm_idx;
            count_nxt = count_r - 1'b1;
            any_nxt   = 1'b1;
            done      = 1'b0;
          end else begin
            ok_nxt = any_r;
          end
        end
        K_RMAT: begin
          if (pos_ok) begin
            op        = CELL_DROP;
            op_pos    = pos_idx;
            count_nxt = count_r - 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        K_REPL: begin
          if (pos_ok) begin
            op     = CELL_WRITE;
            op_pos = pos_idx;
            ok_nxt = 1'b1;
          end
        end
        K_CLEAR: begin
          count_nxt = '0;
          ok_nxt    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    case (state_r)
      ST_EXEC: begin
        busy       = 1'b1;
        strobe_nxt = done;
      end
      default: begin
        busy       = 1'b0;
        strobe_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
      any_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      any_r    <= any_nxt;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_t'(in_kind);
      handle_r <= in_tile_handle;
      image_r  <= in_image_key;
      area_r   <= AREA_BITS'(in_tile_area);
      high_r   <= in_high_mark;
      prio_r   <= in_prioritize;
      status_r <= in_tile_status;
      pos_r    <= in_position;
    end
    ok_r    <= ok_nxt;
    tile_r  <= tile_nxt;
    found_r <= found_nxt;
  end

  // Result ports; occupancy and head status follow the updated chain.
  assign out_strobe      = strobe_r;
  assign out_ok          = ok_r;
  assign out_tile_out    = tile_r;
  assign out_found_index = found_r;
  assign out_occupancy   = OCC_W'(count_r);
  assign out_head_status = (count_r != '0) ? c_status[0] : '0;

  // A result only follows an executing cycle.
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_EXEC))
    else $error("result strobe without an executing item");

  // Occupancy never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("occupancy above queue depth");

  // Occupancy only changes while an item executes.
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> $stable(count_r))
    else $error("occupancy changed while idle");

endmodule
